// ----- rtl/rnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rnc_pkg
// Shared codes, field widths and control types of the reachable node counter.
// ----------------------------------------------------------------------------
package rnc_pkg;

  localparam int OP_W       = 2;   // operation field
  localparam int NODE_W     = 14;  // node_a / node_b fields
  localparam int COUNT_W    = 15;  // fallen_count field
  localparam int IN_DATA_W  = 32;  // node_a, node_b, zero fill
  localparam int OUT_DATA_W = 16;  // fallen_count, edge_overflow

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_KNOCK    = 2'd1,
    OP_END_CASE = 2'd2
  } op_t;

  // Walk stack command from the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// ----- rtl/rnc_ram.sv -----
// ----------------------------------------------------------------------------
// rnc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rnc_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/rnc_walk_stack.sv -----
// ----------------------------------------------------------------------------
// rnc_walk_stack
// Depth-first walk stack: depth counter over a RAM, pop data registered for the next cycle.
// ----------------------------------------------------------------------------
module rnc_walk_stack #(
  parameter int DEPTH = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rnc_pkg::stack_cmd_t                   cmd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] push_node,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pop_node,
  output logic                                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);

  logic [SW-1:0] depth_r;
  logic [SW-1:0] depth_nxt;
  logic          wr_en;
  logic          rd_en;

  assign wr_en = cmd.push && (32'(depth_r) < DEPTH);
  assign rd_en = cmd.pop && (depth_r != '0);
  assign empty = (depth_r == '0);

  always_comb begin
    depth_nxt = depth_r;
    if (wr_en) begin
      depth_nxt = depth_r + 1'b1;
    end else if (rd_en) begin
      depth_nxt = depth_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  rnc_ram #(
    .DEPTH (DEPTH),
    .WIDTH (AW)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(depth_r)),
    .wr_data (push_node),
    .rd_en   (rd_en),
    .rd_addr (AW'(depth_r - 1'b1)),
    .rd_data (pop_node)
  );

endmodule

// ----- rtl/reachable_node_counter.sv -----
// ----------------------------------------------------------------------------
// reachable_node_counter
// Counts graph nodes reachable from knocked start nodes, case by case.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_tready is low while it runs. An add
// edge reads the source's node word and links the edge in front of its list, or
// is dropped when a node is out of range or the edge table is full. A knock
// reads its start node and stops there when the node is already visited or out
// of range; otherwise it walks each newly reached node (pop, head lookup) and
// each stored edge leaving it (edge read, target lookup). An unused operation
// code is ignored. An end case posts the report (waiting if the previous report
// is still held) and then clears the node table; the same clearing pass runs
// after reset before in_tready rises. The node table has a single read port with
// registered read data, so each lookup of the walk waits for its registered data.
// ----------------------------------------------------------------------------
module reachable_node_counter #(
  parameter int NODE_COUNT    = 16384,
  parameter int EDGE_CAPACITY = 16384
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rnc_pkg::IN_DATA_W-1:0]    in_tdata,   // node_a[13:0], node_b[27:14], zero
  input  logic [rnc_pkg::OP_W-1:0]         in_tuser,   // operation[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rnc_pkg::OUT_DATA_W-1:0]   out_tdata   // fallen_count[14:0], edge_overflow[15]
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int PW = $clog2(EDGE_CAPACITY + 1);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int NODE_WORD_W = PW + 1;   // {visited, head}
  localparam int EDGE_WORD_W = NW + PW;  // {target, next}

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD, S_START, S_POP, S_HEAD, S_HEADW,
    S_EDGE, S_EDGEW, S_TGT, S_REPORT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [NW-1:0]                  node_r, node_nxt;
  logic [NW-1:0]                  tgt_r, tgt_nxt;
  logic [PW-1:0]                  e_r, e_nxt;
  logic [PW-1:0]                  used_r, used_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [NW-1:0]                  clr_r, clr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rnc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                       node_wr_en, node_rd_en;
  logic [NW-1:0]              node_wr_addr, node_rd_addr;
  logic [NODE_WORD_W-1:0]     node_wr_data, node_rd_data;
  logic                       edge_wr_en, edge_rd_en;
  logic [EW-1:0]              edge_wr_addr, edge_rd_addr;
  logic [EDGE_WORD_W-1:0]     edge_wr_data, edge_rd_data;
  rnc_pkg::stack_cmd_t        stk_cmd;
  logic [NW-1:0]              stk_push_node, stk_pop_node;
  logic                       stk_empty;

  logic [rnc_pkg::NODE_W-1:0] a_in, b_in;
  logic                       a_ok, b_ok, in_fire;
  logic                       rd_visited;
  logic [PW-1:0]              rd_head;

  assign a_in       = in_tdata[rnc_pkg::NODE_W-1:0];
  assign b_in       = in_tdata[2*rnc_pkg::NODE_W-1:rnc_pkg::NODE_W];
  assign a_ok       = 32'(a_in) < NODE_COUNT;
  assign b_ok       = 32'(b_in) < NODE_COUNT;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign rd_visited = node_rd_data[PW];
  assign rd_head    = node_rd_data[PW-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    tgt_nxt       = tgt_r;
    e_nxt         = e_r;
    used_nxt      = used_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    clr_nxt       = clr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    node_wr_en    = 1'b0;
    node_wr_addr  = node_r;
    node_wr_data  = {1'b1, rd_head};
    node_rd_en    = 1'b0;
    node_rd_addr  = NW'(a_in);
    edge_wr_en    = 1'b0;
    edge_wr_addr  = EW'(used_r);
    edge_wr_data  = {tgt_r, rd_head};
    edge_rd_en    = 1'b0;
    edge_rd_addr  = EW'(e_r - 1'b1);
    stk_cmd       = '0;
    stk_push_node = node_r;

    unique case (state_r)
      S_CLEAR: begin
        node_wr_en   = 1'b1;
        node_wr_addr = clr_r;
        node_wr_data = '0;
        if (32'(clr_r) == NODE_COUNT - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          node_nxt = NW'(a_in);
          tgt_nxt  = NW'(b_in);
          unique case (rnc_pkg::op_t'(in_tuser))
            rnc_pkg::OP_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                if (32'(used_r) >= EDGE_CAPACITY) begin
                  ovf_nxt = 1'b1;
                end else begin
                  node_rd_en = 1'b1;
                  state_nxt  = S_ADD;
                end
              end
            end
            rnc_pkg::OP_KNOCK: begin
              if (a_ok) begin
                node_rd_en = 1'b1;
                state_nxt  = S_START;
              end
            end
            rnc_pkg::OP_END_CASE: begin
              state_nxt = S_REPORT;
            end
            default: begin
            end
          endcase
        end
      end

      // link the new edge in front of the source's list
      S_ADD: begin
        edge_wr_en   = 1'b1;
        node_wr_en   = 1'b1;
        node_wr_data = {rd_visited, used_r + 1'b1};
        used_nxt     = used_r + 1'b1;
        state_nxt    = S_IDLE;
      end

      S_START: begin
        if (rd_visited) begin
          state_nxt = S_IDLE;
        end else begin
          node_wr_en   = 1'b1;
          stk_cmd.push = 1'b1;
          count_nxt    = count_r + 1'b1;
          state_nxt    = S_POP;
        end
      end

      S_POP: begin
        if (stk_empty) begin
          state_nxt = S_IDLE;
        end else begin
          stk_cmd.pop = 1'b1;
          state_nxt   = S_HEAD;
        end
      end

      S_HEAD: begin
        node_rd_en   = 1'b1;
        node_rd_addr = stk_pop_node;
        state_nxt    = S_HEADW;
      end

      S_HEADW: begin
        e_nxt     = rd_head;
        state_nxt = S_EDGE;
      end

      S_EDGE: begin
        if (e_r == '0) begin
          state_nxt = S_POP;
        end else begin
          edge_rd_en = 1'b1;
          state_nxt  = S_EDGEW;
        end
      end

      // follow the edge: look up its target, advance to the next edge
      S_EDGEW: begin
        e_nxt        = edge_rd_data[PW-1:0];
        node_nxt     = edge_rd_data[EDGE_WORD_W-1:PW];
        node_rd_en   = 1'b1;
        node_rd_addr = edge_rd_data[EDGE_WORD_W-1:PW];
        state_nxt    = S_TGT;
      end

      S_TGT: begin
        if (!rd_visited) begin
          node_wr_en   = 1'b1;
          stk_cmd.push = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
        state_nxt = S_EDGE;
      end

      S_REPORT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {ovf_r, rnc_pkg::COUNT_W'(count_r)};
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          used_nxt      = '0;
          ovf_nxt       = 1'b0;
          clr_nxt       = '0;
          state_nxt     = S_CLEAR;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      used_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r     <= node_nxt;
    tgt_r      <= tgt_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
  end

  rnc_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_WORD_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data)
  );

  rnc_ram #(
    .DEPTH (EDGE_CAPACITY),
    .WIDTH (EDGE_WORD_W)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_wr_en),
    .wr_addr (edge_wr_addr),
    .wr_data (edge_wr_data),
    .rd_en   (edge_rd_en),
    .rd_addr (edge_rd_addr),
    .rd_data (edge_rd_data)
  );

  rnc_walk_stack #(
    .DEPTH (NODE_COUNT)
  ) u_walk_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_node (stk_push_node),
    .pop_node  (stk_pop_node),
    .empty     (stk_empty)
  );

endmodule

// ----- rtl/rnc_checker.sv -----
// ----------------------------------------------------------------------------
// rnc_checker
// Port-level checks of the reachable node counter, bound to the top level.
// ----------------------------------------------------------------------------
module rnc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [rnc_pkg::OP_W-1:0]       in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rnc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // reset drops any pending report
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // an end case moves to the report state, so no transaction is taken next
  a_end_case_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == rnc_pkg::OP_END_CASE) |=> !in_tready)
    else $error("in_tready high right after end case");

  // a report appears only while the block is busy clearing
  a_report_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("report raised while idle");

  // hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled report changed");

endmodule

bind reachable_node_counter rnc_checker u_rnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams add-edge, knock and end-case transactions into the reachable node
// counter and checks every case report against a behavioral graph walk kept
// in the bench. Covers directed corner cases, a long chain walk, report
// backpressure and random cases under random idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_TOTAL   = 16384;
  localparam int EDGE_SLOTS   = 16384;
  localparam int CHAIN_NODES  = 256;
  localparam int RANDOM_ITEMS = 1450;
  localparam int RANDOM_CASES = 24;
  localparam int LONG_HOLD    = 40000;  // longer than a clearing pass
  localparam int DRAIN_CYCLES = 200;

  // Operation code with no meaning; the block must ignore it.
  localparam logic [rnc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [rnc_pkg::COUNT_W-1:0] fallen_count;
    logic                        edge_overflow;
  } case_report_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [rnc_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [rnc_pkg::OP_W-1:0]       in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rnc_pkg::OUT_DATA_W-1:0] out_tdata;

  // Graph state of the current case, as the block should hold it.
  bit                           node_seen  [NODE_TOTAL];
  logic [rnc_pkg::COUNT_W-1:0]  first_edge [NODE_TOTAL];  // 0 = none, else edge index + 1
  logic [rnc_pkg::NODE_W-1:0]   edge_dest  [EDGE_SLOTS];
  logic [rnc_pkg::COUNT_W-1:0]  edge_link  [EDGE_SLOTS];  // 0 = none, else edge index + 1
  int unsigned                  edge_fill;
  int unsigned                  reached_total;
  bit                           dropped_edge;

  case_report_t pending_reports[$];
  int unsigned  fail_count    = 0;
  bit           sender_idles  = 1'b1;
  int unsigned  burst_left    = 0;
  int unsigned  hold_requests = 0;
  int unsigned  hold_served   = 0;
  int unsigned  hold_left     = 0;
  logic [15:0]  ready_pattern = 16'hFFFF;
  int unsigned  pattern_age   = 0;

  reachable_node_counter #(
    .NODE_COUNT    (NODE_TOTAL),
    .EDGE_CAPACITY (EDGE_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(20ms);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- graph walk

  function automatic void clear_graph();
    foreach (node_seen[i]) begin
      node_seen[i]  = 1'b0;
      first_edge[i] = '0;
    end
    edge_fill     = 0;
    reached_total = 0;
    dropped_edge  = 1'b0;
  endfunction

  function automatic void knock_node(logic [rnc_pkg::NODE_W-1:0] start);
    int unsigned                 walk[$];
    int unsigned                 node_n;
    logic [rnc_pkg::COUNT_W-1:0] link;
    if (node_seen[start]) return;
    node_seen[start] = 1'b1;
    reached_total++;
    walk.push_back(start);
    while (walk.size() != 0) begin
      node_n = walk.pop_back();
      link = first_edge[node_n];
      while (link != 0) begin
        if (!node_seen[edge_dest[link - 1]]) begin
          node_seen[edge_dest[link - 1]] = 1'b1;
          reached_total++;
          walk.push_back(edge_dest[link - 1]);
        end
        link = edge_link[link - 1];
      end
    end
  endfunction

  function automatic void apply_to_graph(logic [rnc_pkg::OP_W-1:0] op,
                                         logic [rnc_pkg::NODE_W-1:0] a,
                                         logic [rnc_pkg::NODE_W-1:0] b);
    case_report_t rep;
    case (op)
      rnc_pkg::OP_ADD_EDGE: begin
        if (edge_fill >= EDGE_SLOTS) begin
          dropped_edge = 1'b1;
        end else begin
          edge_dest[edge_fill] = b;
          edge_link[edge_fill] = first_edge[a];
          first_edge[a] = rnc_pkg::COUNT_W'(edge_fill + 1);
          edge_fill++;
        end
      end
      rnc_pkg::OP_KNOCK: knock_node(a);
      rnc_pkg::OP_END_CASE: begin
        rep.fallen_count  = reached_total[rnc_pkg::COUNT_W-1:0];
        rep.edge_overflow = dropped_edge;
        pending_reports.push_back(rep);
        clear_graph();
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_item(input logic [rnc_pkg::OP_W-1:0] op,
                           input logic [rnc_pkg::NODE_W-1:0] a,
                           input logic [rnc_pkg::NODE_W-1:0] b);
    int unsigned gap;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    apply_to_graph(op, a, b);
  endtask

  // Drop valid before any pause so the last transaction is not taken twice.
  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready  <= ready_pattern[0];
      pattern_age <= pattern_age + 1;
      if (pattern_age % 64 == 63) begin
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    case_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("fallen_count: no report expected, actual %0d",
               out_tdata[rnc_pkg::COUNT_W-1:0]);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[rnc_pkg::COUNT_W-1:0] !== want.fallen_count) begin
          $error("fallen_count: expected %0d, actual %0d",
                 want.fallen_count, out_tdata[rnc_pkg::COUNT_W-1:0]);
          fail_count++;
        end
        if (out_tdata[rnc_pkg::COUNT_W] !== want.edge_overflow) begin
          $error("edge_overflow: expected %0b, actual %0b",
                 want.edge_overflow, out_tdata[rnc_pkg::COUNT_W]);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed_cases();
    sender_idles = 1'b0;
    send_item(rnc_pkg::OP_END_CASE, '0, '0);                 // empty case
    send_item(OP_UNUSED, 14'h3FFF, 14'h3FFF);
    send_item(rnc_pkg::OP_ADD_EDGE, 14'd0, 14'h3FFF);
    send_item(rnc_pkg::OP_ADD_EDGE, 14'h3FFF, 14'd0);        // cycle back to start
    send_item(rnc_pkg::OP_ADD_EDGE, 14'h3FFF, 14'h3FFF);     // self loop
    send_item(rnc_pkg::OP_ADD_EDGE, 14'd0, 14'h3FFF);        // duplicate edge
    send_item(rnc_pkg::OP_ADD_EDGE, 14'd5, 14'd6);
    send_item(rnc_pkg::OP_KNOCK, 14'd0, 14'h3FFF);
    send_item(rnc_pkg::OP_KNOCK, 14'h3FFF, 14'd0);           // already visited
    send_item(rnc_pkg::OP_KNOCK, 14'd6, 14'h2AAA);
    send_item(OP_UNUSED, 14'd0, 14'd0);
    send_item(rnc_pkg::OP_ADD_EDGE, 14'd6, 14'd9);
    send_item(rnc_pkg::OP_KNOCK, 14'd6, 14'h1555);           // new edge from a visited node
    send_item(rnc_pkg::OP_END_CASE, 14'h3FFF, 14'h3FFF);
    send_item(rnc_pkg::OP_END_CASE, 14'h2AAA, 14'h1555);     // back to back, nothing left
    send_item(rnc_pkg::OP_KNOCK, 14'h3FFF, 14'd0);           // knock with no edges
    send_item(rnc_pkg::OP_END_CASE, '0, '0);
  endtask

  // Chain a run of nodes ending at the top node, close the loop, walk it all.
  task automatic test_long_chain();
    int unsigned first;
    first = NODE_TOTAL - CHAIN_NODES;
    sender_idles = 1'b0;
    for (int i = 0; i < CHAIN_NODES - 1; i++) begin
      send_item(rnc_pkg::OP_ADD_EDGE, rnc_pkg::NODE_W'(first + i),
                rnc_pkg::NODE_W'(first + i + 1));
    end
    send_item(rnc_pkg::OP_ADD_EDGE, 14'h3FFF, rnc_pkg::NODE_W'(first));
    sender_idles = 1'b1;
    send_item(rnc_pkg::OP_KNOCK, rnc_pkg::NODE_W'(first), '0);
    send_item(rnc_pkg::OP_KNOCK, 14'h3FFF, '0);
    send_item(rnc_pkg::OP_END_CASE, '0, '0);
    send_item(rnc_pkg::OP_END_CASE, '0, '0);
  endtask

  task automatic test_report_backpressure();
    sender_idles = 1'b0;
    hold_requests++;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 5; i++) begin
        send_item(rnc_pkg::OP_ADD_EDGE, rnc_pkg::NODE_W'(200 + i),
                  rnc_pkg::NODE_W'(201 + i + c));
      end
      send_item(rnc_pkg::OP_KNOCK, rnc_pkg::NODE_W'(200 + c), '0);
      send_item(rnc_pkg::OP_END_CASE, '0, '0);
    end
    go_quiet();
    while (pending_reports.size() != 0) @(posedge clk);
    sender_idles = 1'b1;
    send_item(rnc_pkg::OP_ADD_EDGE, 14'd7, 14'd8);
    send_item(rnc_pkg::OP_KNOCK, 14'd7, '0);
    send_item(rnc_pkg::OP_END_CASE, '0, '0);
  endtask

  task automatic test_random_cases();
    int unsigned                counted;
    int unsigned                cases;
    int unsigned                items;
    int unsigned                span;
    int unsigned                base;
    int unsigned                pick;
    logic [rnc_pkg::NODE_W-1:0] a;
    logic [rnc_pkg::NODE_W-1:0] b;
    counted = 0;
    cases   = 0;
    while (counted < RANDOM_ITEMS || cases < RANDOM_CASES) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      span = (pick < 5) ? 15 : (pick < 8) ? 63 : (pick < 9) ? 1023 : NODE_TOTAL - 1;
      base = $urandom_range(0, NODE_TOTAL - 1 - span);
      items = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 90);
      repeat (items) begin
        a = rnc_pkg::NODE_W'(base + $urandom_range(0, span));
        b = rnc_pkg::NODE_W'(base + $urandom_range(0, span));
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          send_item(rnc_pkg::OP_ADD_EDGE, a, b);
          counted++;
        end else if (pick < 90) begin
          send_item(rnc_pkg::OP_KNOCK, a, rnc_pkg::NODE_W'($urandom()));
          counted++;
        end else begin
          send_item(OP_UNUSED, rnc_pkg::NODE_W'($urandom()), rnc_pkg::NODE_W'($urandom()));
        end
      end
      send_item(rnc_pkg::OP_END_CASE, rnc_pkg::NODE_W'($urandom()),
                rnc_pkg::NODE_W'($urandom()));
      counted++;
      cases++;
    end
  endtask

  initial begin
    clear_graph();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_long_chain();
    test_report_backpressure();
    test_random_cases();
    go_quiet();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- reachable_node_counter.f -----
rtl/rnc_pkg.sv
rtl/rnc_ram.sv
rtl/rnc_walk_stack.sv
rtl/reachable_node_counter.sv
rtl/rnc_checker.sv
bench/testbench.sv
